[hdl/counted_frame_crc16_checker_core_defines.svh]
// Assertion macros used by the port checker of the counted-frame CRC-16 checker.
`ifndef COUNTED_FRAME_CRC16_CHECKER_CORE_DEFINES_SVH
`define COUNTED_FRAME_CRC16_CHECKER_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CFC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cfc assertion failed");

// Clocked assertion that also holds during reset.
`define CFC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cfc assertion failed");

`endif

[hdl/cfc_pkg.sv]
// Package with the shared constants and types of the counted-frame CRC-16 checker.
`timescale 1ns / 1ps

package cfc_pkg;

    localparam logic [15:0] CRC_POLY  = 16'h8005;
    localparam logic [7:0]  MIN_COUNT = 8'd4;

    typedef enum logic [1:0] {
        STATUS_BUSY      = 2'd0,
        STATUS_GOOD      = 2'd1,
        STATUS_CRC_ERR   = 2'd2,
        STATUS_BAD_COUNT = 2'd3
    } status_t;

    // Fields of one result word.
    typedef struct packed {
        status_t    status;
        logic       frame_done;
        logic       is_payload;
        logic [7:0] data_byte;
    } result_t;

endpackage

[hdl/cfc_crc_byte.sv]
// One-byte CRC-16 update, data taken least significant bit first.
`timescale 1ns / 1ps

module cfc_crc_byte
    import cfc_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] acc;
        acc = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            if (data_in[i] != acc[15])
            begin
                acc = {acc[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                acc = {acc[14:0], 1'b0};
            end
        end
        crc_out = acc;
    end

endmodule

[hdl/counted_frame_crc16_checker_core.sv]
// Top level of the counted-frame CRC-16 checker.
// A word accepted at the input is held in the input register and then in
// the result register before it shows at the output.
// Throughput: one word per cycle while the output is not stalled; the frame
// state and the byte CRC update sit between the input and result registers.
// Reset (rst_n low, asynchronous) empties both registers, returns the parser
// to awaiting a count byte with the CRC at zero, and clears req_count_reg.
`timescale 1ns / 1ps

module counted_frame_crc16_checker_core
    import cfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [2:0] m_axis_tuser,   // [0] is_payload, [2:1] status
    output logic       m_axis_tlast    // frame_done
);

    logic [7:0]  req_count_reg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic        lo_ok_reg, lo_ok_next;

    logic        out_free;
    logic        proc_go;
    logic [15:0] crc_feed_in;
    logic [15:0] crc_fed;
    logic [8:0]  pos_plus2;
    logic        count_bad;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc_go       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // A count byte starts a fresh CRC.
    assign crc_feed_in = (pos_reg == 8'd0) ? 16'h0000 : crc_reg;

    cfc_crc_byte u_crc_byte (
        .crc_in  (crc_feed_in),
        .data_in (in_byte_reg),
        .crc_out (crc_fed)
    );

    assign pos_plus2 = {1'b0, pos_reg} + 9'd2;
    assign count_bad = (in_byte_reg < MIN_COUNT)
                    || ((req_count_reg != 8'd0) && (in_byte_reg != req_count_reg));

    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        lo_ok_next = lo_ok_reg;
        out_next.data_byte  = in_byte_reg;
        out_next.is_payload = 1'b0;
        out_next.frame_done = 1'b0;
        out_next.status     = STATUS_BUSY;
        if (pos_reg == 8'd0)
        begin
            if (count_bad)
            begin
                out_next.frame_done = 1'b1;
                out_next.status     = STATUS_BAD_COUNT;
                crc_next            = 16'h0000;
            end
            else
            begin
                len_next   = in_byte_reg;
                crc_next   = crc_fed;
                lo_ok_next = 1'b0;
                pos_next   = 8'd1;
            end
        end
        else if (pos_plus2 < {1'b0, len_reg})
        begin
            out_next.is_payload = 1'b1;
            crc_next            = crc_fed;
            pos_next            = pos_reg + 8'd1;
        end
        else if (pos_plus2 == {1'b0, len_reg})
        begin
            lo_ok_next = (in_byte_reg == crc_reg[7:0]);
            pos_next   = pos_reg + 8'd1;
        end
        else
        begin
            out_next.frame_done = 1'b1;
            out_next.status     = (lo_ok_reg && (in_byte_reg == crc_reg[15:8]))
                                  ? STATUS_GOOD : STATUS_CRC_ERR;
            pos_next            = 8'd0;
            crc_next            = 16'h0000;
            lo_ok_next          = 1'b0;
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_go)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_count_reg <= 8'd0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= 8'd0;
            len_reg       <= 8'd0;
            crc_reg       <= 16'h0000;
            lo_ok_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                req_count_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc_go)
            begin
                pos_reg   <= pos_next;
                len_reg   <= len_next;
                crc_reg   <= crc_next;
                lo_ok_reg <= lo_ok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (proc_go)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.data_byte;
    assign m_axis_tuser  = {out_reg.status, out_reg.is_payload};
    assign m_axis_tlast  = out_reg.frame_done;

endmodule

[hdl/cfc_port_checker.sv]
// Port-level assertions for the counted-frame CRC-16 checker, bound to the top level.
`timescale 1ns / 1ps
`include "counted_frame_crc16_checker_core_defines.svh"

module cfc_port_checker
    import cfc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    logic        out_stall;
    logic [11:0] out_word;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    // A stalled output word holds its contents.
    `CFC_ASSERT(a_out_hold, clk, rst_n, out_stall |=> m_axis_tvalid && $stable(out_word))

    // A word ends a frame exactly when it carries a final status.
    `CFC_ASSERT(a_last_status, clk, rst_n, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[2:1] != STATUS_BUSY)))

    // Payload words never close a frame.
    `CFC_ASSERT(a_payload_busy, clk, rst_n, m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tlast && (m_axis_tuser[2:1] == STATUS_BUSY))

    // Nothing is offered while reset is held.
    `CFC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !m_axis_tvalid)

endmodule

bind counted_frame_crc16_checker_core cfc_port_checker u_cfc_port_checker (.*);
